### design/kermit_prefix_codec_top_defines.svh
// assertion macros for the kermit prefix codec checker
// no dependencies
`ifndef KERMIT_PREFIX_CODEC_TOP_DEFINES_SVH
`define KERMIT_PREFIX_CODEC_TOP_DEFINES_SVH

// clocked assertion, off while reset is low
`define KPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/kpc_pkg.sv
// shared types, constants and helper functions of the kermit prefix codec
// no dependencies
package kpc_pkg;

    localparam logic [7:0] CH_Y      = 8'h59;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] RANGE_LO1 = 8'd32;
    localparam logic [7:0] RANGE_HI1 = 8'd62;
    localparam logic [7:0] RANGE_LO2 = 8'd96;
    localparam logic [7:0] RANGE_HI2 = 8'd126;
    localparam logic [6:0] CH_DEL    = 7'd127;
    localparam logic [6:0] CTL_LIMIT = 7'd32;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [7:0] CTL_FLIP  = 8'h40;

    localparam logic REG_CTL = 1'b0;
    localparam logic REG_BIN = 1'b1;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0] qc;
        logic [7:0] qb;
        logic       ce;
        logic       be;
    } t_prefix_cfg;

    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            pend_ctl;
        logic            pend_bin;
    } t_expand;

    function automatic logic in_prefix_range(input logic [7:0] c);
        return (c >= RANGE_LO1 && c <= RANGE_HI1) || (c >= RANGE_LO2 && c <= RANGE_HI2);
    endfunction

    function automatic logic is_ctl_char(input logic [7:0] c);
        return (c[6:0] == CH_DEL) || (c[6:0] < CTL_LIMIT);
    endfunction

endpackage

### design/kpc_in_if.sv
// input channel of the kermit prefix codec: op and data byte
// uses no package
interface kpc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

### design/kpc_out_if.sv
// output channel of the kermit prefix codec: result byte and last flag
// uses no package
interface kpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

### design/kpc_cfg.sv
// apb register file for the two prefix characters and their enable logic
// depends on kpc_pkg
module kpc_cfg
    import kpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_prefix_cfg o_cfg
);

    logic [7:0] r_ctl;
    logic [7:0] r_bin;
    logic       wr_en;
    logic [7:0] qb;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= 8'd35;
            r_bin <= CH_SPACE;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CTL: r_ctl <= pwdata[7:0];
                REG_BIN: r_bin <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign prdata = {24'd0, (paddr[2] == REG_BIN) ? r_bin : r_ctl};

    assign qb = (r_bin == CH_Y) ? CH_AMP : r_bin;

    always_comb begin
        o_cfg.qc = r_ctl;
        o_cfg.qb = qb;
        o_cfg.ce = (r_ctl != qb) && (r_ctl != CH_SPACE) && in_prefix_range(r_ctl);
        o_cfg.be = (r_ctl != qb) && (qb != CH_SPACE) && in_prefix_range(qb);
    end

endmodule

### design/kpc_expand.sv
// expands one item into up to three result bytes and the next decode flags
// depends on kpc_pkg
module kpc_expand
    import kpc_pkg::*;
(
    input  t_prefix_cfg i_cfg,
    input  t_op         i_op,
    input  logic [7:0]  i_byte,
    input  logic        i_pend_ctl,
    input  logic        i_pend_bin,
    output t_expand     o_exp
);

    logic       hb;
    logic [7:0] b1;
    logic       tail2;
    logic [7:0] t1;
    logic [7:0] v;
    logic       qc_hit;
    logic       qb_hit;

    always_comb begin
        hb     = i_cfg.be && i_byte[7];
        b1     = hb ? (i_byte ^ HIGH_BIT) : i_byte;
        tail2  = i_cfg.ce && ((b1 == i_cfg.qc) || (i_cfg.be && b1 == i_cfg.qb)
                 || is_ctl_char(b1));
        priority if (b1 == i_cfg.qc) begin
            t1 = i_cfg.qc;
        end else if (i_cfg.be && b1 == i_cfg.qb) begin
            t1 = i_cfg.qb;
        end else begin
            t1 = b1 ^ CTL_FLIP;
        end

        qc_hit = (i_byte == i_cfg.qc);
        qb_hit = i_cfg.be && (i_byte == i_cfg.qb);
        v      = (qc_hit || qb_hit) ? i_byte : (i_byte ^ CTL_FLIP);
        if (i_pend_bin) begin
            v = v ^ HIGH_BIT;
        end

        o_exp.pend_ctl = i_pend_ctl;
        o_exp.pend_bin = i_pend_bin;
        o_exp.bytes    = '0;
        o_exp.count    = 2'd1;

        unique case (i_op)
            OP_ENCODE: begin
                if (hb) begin
                    o_exp.bytes[0] = i_cfg.qb;
                    o_exp.bytes[1] = tail2 ? i_cfg.qc : b1;
                    o_exp.bytes[2] = t1;
                    o_exp.count    = tail2 ? 2'd3 : 2'd2;
                end else begin
                    o_exp.bytes[0] = tail2 ? i_cfg.qc : b1;
                    o_exp.bytes[1] = t1;
                    o_exp.count    = tail2 ? 2'd2 : 2'd1;
                end
            end
            OP_DECODE: begin
                priority if (i_pend_ctl) begin
                    o_exp.bytes[0] = v;
                    o_exp.pend_ctl = 1'b0;
                    o_exp.pend_bin = 1'b0;
                end else if (i_pend_bin) begin
                    if (i_cfg.ce && qc_hit) begin
                        o_exp.pend_ctl = 1'b1;
                        o_exp.count    = 2'd0;
                    end else begin
                        o_exp.bytes[0] = i_byte ^ HIGH_BIT;
                        o_exp.pend_bin = 1'b0;
                    end
                end else if (i_cfg.ce && qc_hit) begin
                    o_exp.pend_ctl = 1'b1;
                    o_exp.count    = 2'd0;
                end else if (qb_hit) begin
                    o_exp.pend_bin = 1'b1;
                    o_exp.count    = 2'd0;
                end else begin
                    o_exp.bytes[0] = i_byte;
                end
            end
            default: ;
        endcase
    end

endmodule

### design/kpc_seq.sv
// decode flags, expansion register and output register; one result byte per cycle unless the output stalls
// depends on kpc_pkg, kpc_expand
module kpc_seq
    import kpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_prefix_cfg i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_in_op,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last
);

    logic            r_pend_ctl;
    logic            r_pend_bin;
    logic            r_exp_v;
    logic [1:0]      r_cnt;
    logic [1:0]      r_idx;
    logic [2:0][7:0] r_bytes;
    logic            r_out_v;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    t_expand n_exp;
    logic    out_load;
    logic    push;
    logic    is_last;
    logic    accept;

    kpc_expand u_expand (
        .i_cfg      (i_cfg),
        .i_op       (t_op'(i_in_op)),
        .i_byte     (i_in_byte),
        .i_pend_ctl (r_pend_ctl),
        .i_pend_bin (r_pend_bin),
        .o_exp      (n_exp)
    );

    assign out_load   = !r_out_v || i_out_ready;
    assign push       = r_exp_v && out_load;
    assign is_last    = (r_idx + 2'd1) == r_cnt;
    assign o_in_ready = !r_exp_v || (push && is_last);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_ctl <= 1'b0;
            r_pend_bin <= 1'b0;
            r_exp_v    <= 1'b0;
            r_out_v    <= 1'b0;
            r_idx      <= 2'd0;
        end else begin
            if (accept) begin
                r_pend_ctl <= n_exp.pend_ctl;
                r_pend_bin <= n_exp.pend_bin;
                r_exp_v    <= n_exp.count != 2'd0;
                r_idx      <= 2'd0;
            end else if (push) begin
                if (is_last) begin
                    r_exp_v <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (out_load) begin
                r_out_v <= push;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt   <= n_exp.count;
            r_bytes <= n_exp.bytes;
        end
        if (push) begin
            r_out_byte <= r_bytes[r_idx];
            r_out_last <= is_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

### design/kermit_prefix_codec_top.sv
// top level of the kermit prefix codec: apb registers and the byte sequencer
// depends on kpc_pkg, kpc_in_if, kpc_out_if, kpc_cfg, kpc_seq
//
// channel   dir  handshake        payload
// i_in      in   valid/ready      op, data_byte
// o_out     out  valid/ready      out_byte, last
// apb       in   psel/penable     paddr[2] selects ctl_prefix (0) or bin_prefix (4)
//
// one result byte per cycle unless the output stalls: an encoded item gives 1 to 3 bytes,
// a decoded item 0 or 1, set by the single expansion register that feeds the output register
// a decode prefix byte gives no result and leaves the expansion register empty
// synchronous active-low reset clears flags and valids; prefixes reset to '#' and ' '
// a stalled output keeps its byte; the next item is taken as the last byte moves out
module kermit_prefix_codec_top
    import kpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpc_in_if.sink      i_in,
    kpc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_prefix_cfg cfg;

    kpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kpc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_op     (i_in.op),
        .i_in_byte   (i_in.data_byte),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last)
    );

endmodule

### design/kpc_checker.sv
// port-level checks of the kermit prefix codec, bound to the top level
// depends on kermit_prefix_codec_top_defines.svh
`include "kermit_prefix_codec_top_defines.svh"

module kpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    `KPC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `KPC_ASSERT(a_out_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output dropped while stalled")
    `KPC_ASSERT(a_wr_readback, i_clk, i_rst_n, psel && penable && pwrite |=> (paddr[2] != $past(paddr[2])) || (prdata[7:0] == $past(pwdata[7:0])), "register readback mismatch")
    `KPC_ASSERT(a_mid_item_stall, i_clk, i_rst_n, i_out_valid && !i_out_last && !i_out_ready |-> !i_in_ready, "input taken while an item is still expanding")
    `KPC_ASSERT_ALWAYS(a_pready_high, i_clk, pready, "pready low")

endmodule

bind kermit_prefix_codec_top kpc_checker u_kpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);
